/* rtl/pcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the polygon convexity classifier.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int TURN_COUNT = 3;
    localparam int TERM_COUNT = 4;

    localparam int TURN_MAIN  = 0;
    localparam int TURN_WRAPA = 1;
    localparam int TURN_WRAPB = 2;

    localparam int TERM_A = 0;
    localparam int TERM_B = 1;
    localparam int TERM_C = 2;
    localparam int TERM_D = 3;

    localparam logic [1:0] FULL_COUNT = 2'd3;

    typedef enum logic [1:0] {
        CLASS_DEGENERATE = 2'd0,
        CLASS_CONVEX     = 2'd1,
        CLASS_CONCAVE    = 2'd2
    } shape_class_t;

    typedef struct packed {
        logic [TURN_COUNT-1:0] turn_en;
        logic                  last;
    } job_ctrl_t;

endpackage

/* rtl/pcc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_front
// Holds the first, second, older and recent vertices and turns each accepted
// vertex into a job of up to three cross product operand sets.
// ----------------------------------------------------------------------------
module pcc_front
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             accept,
    input  logic signed [COORD_WIDTH-1:0]                    vertex_x,
    input  logic signed [COORD_WIDTH-1:0]                    vertex_y,
    input  logic                                             final_vertex,
    output job_ctrl_t                                        job_ctrl,
    output logic [TURN_COUNT*TERM_COUNT*(COORD_WIDTH+1)-1:0] job_data
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] first_x_reg;
    logic signed [COORD_WIDTH-1:0] first_y_reg;
    logic signed [COORD_WIDTH-1:0] second_x_reg;
    logic signed [COORD_WIDTH-1:0] second_y_reg;
    logic signed [COORD_WIDTH-1:0] older_x_reg;
    logic signed [COORD_WIDTH-1:0] older_y_reg;
    logic signed [COORD_WIDTH-1:0] recent_x_reg;
    logic signed [COORD_WIDTH-1:0] recent_y_reg;
    logic [1:0]                    seen_count_reg;
    logic [1:0]                    seen_count_next;

    logic signed [COORD_WIDTH-1:0] ix [TURN_COUNT];
    logic signed [COORD_WIDTH-1:0] iy [TURN_COUNT];
    logic signed [COORD_WIDTH-1:0] jx [TURN_COUNT];
    logic signed [COORD_WIDTH-1:0] jy [TURN_COUNT];
    logic signed [COORD_WIDTH-1:0] kx [TURN_COUNT];
    logic signed [COORD_WIDTH-1:0] ky [TURN_COUNT];

    always_comb
    begin
        ix[TURN_MAIN]  = older_x_reg;
        iy[TURN_MAIN]  = older_y_reg;
        jx[TURN_MAIN]  = recent_x_reg;
        jy[TURN_MAIN]  = recent_y_reg;
        kx[TURN_MAIN]  = vertex_x;
        ky[TURN_MAIN]  = vertex_y;
        ix[TURN_WRAPA] = recent_x_reg;
        iy[TURN_WRAPA] = recent_y_reg;
        jx[TURN_WRAPA] = vertex_x;
        jy[TURN_WRAPA] = vertex_y;
        kx[TURN_WRAPA] = first_x_reg;
        ky[TURN_WRAPA] = first_y_reg;
        ix[TURN_WRAPB] = vertex_x;
        iy[TURN_WRAPB] = vertex_y;
        jx[TURN_WRAPB] = first_x_reg;
        jy[TURN_WRAPB] = first_y_reg;
        kx[TURN_WRAPB] = second_x_reg;
        ky[TURN_WRAPB] = second_y_reg;
    end

    always_comb
    begin
        for (int t = 0; t < TURN_COUNT; t++)
        begin
            job_data[(t*TERM_COUNT+TERM_A)*DW +: DW] =
                DW'($signed({jx[t][COORD_WIDTH-1], jx[t]}) - $signed({ix[t][COORD_WIDTH-1], ix[t]}));
            job_data[(t*TERM_COUNT+TERM_B)*DW +: DW] =
                DW'($signed({ky[t][COORD_WIDTH-1], ky[t]}) - $signed({jy[t][COORD_WIDTH-1], jy[t]}));
            job_data[(t*TERM_COUNT+TERM_C)*DW +: DW] =
                DW'($signed({jy[t][COORD_WIDTH-1], jy[t]}) - $signed({iy[t][COORD_WIDTH-1], iy[t]}));
            job_data[(t*TERM_COUNT+TERM_D)*DW +: DW] =
                DW'($signed({kx[t][COORD_WIDTH-1], kx[t]}) - $signed({jx[t][COORD_WIDTH-1], jx[t]}));
        end
    end

    // A turn exists once two vertices are held; the wrap turns only on the last vertex.
    always_comb
    begin
        job_ctrl.last                = final_vertex;
        job_ctrl.turn_en[TURN_MAIN]  = seen_count_reg[1];
        job_ctrl.turn_en[TURN_WRAPA] = seen_count_reg[1] & final_vertex;
        job_ctrl.turn_en[TURN_WRAPB] = seen_count_reg[1] & final_vertex;
    end

    always_comb
    begin
        if (final_vertex)
        begin
            seen_count_next = 2'd0;
        end
        else if (seen_count_reg < FULL_COUNT)
        begin
            seen_count_next = seen_count_reg + 2'd1;
        end
        else
        begin
            seen_count_next = seen_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            seen_count_reg <= seen_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (seen_count_reg == 2'd0)
            begin
                first_x_reg <= vertex_x;
                first_y_reg <= vertex_y;
            end
            if (seen_count_reg == 2'd1)
            begin
                second_x_reg <= vertex_x;
                second_y_reg <= vertex_y;
            end
            older_x_reg  <= recent_x_reg;
            older_y_reg  <= recent_y_reg;
            recent_x_reg <= vertex_x;
            recent_y_reg <= vertex_y;
        end
    end

endmodule

/* rtl/pcc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_queue
// Small first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module pcc_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop_ready,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/pcc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_back
// Multiplies, takes cross product signs, gathers turn directions per polygon
// and holds the class in the output register.
// ----------------------------------------------------------------------------
module pcc_back
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             job_valid,
    input  job_ctrl_t                                        job_ctrl,
    input  logic [TURN_COUNT*TERM_COUNT*(COORD_WIDTH+1)-1:0] job_data,
    output logic                                             job_ready,
    output logic                                             out_valid,
    input  logic                                             out_stall,
    output logic [1:0]                                       shape_class
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                 advance;
    logic                 p_valid_reg;
    job_ctrl_t            p_ctrl_reg;
    logic signed [PW-1:0] prod_ab_reg [TURN_COUNT];
    logic signed [PW-1:0] prod_cd_reg [TURN_COUNT];
    logic                 s_valid_reg;
    logic                 s_last_reg;
    logic [1:0]           s_signs_reg;
    logic [1:0]           s_signs_next;
    logic [1:0]           acc_reg;
    logic [1:0]           merged;
    logic                 out_valid_reg;
    shape_class_t         class_reg;
    shape_class_t         class_next;
    logic signed [PW:0]   cross_val [TURN_COUNT];

    assign advance   = !(out_valid_reg && out_stall);
    assign job_ready = advance;

    // Bit 0 records a negative turn, bit 1 a positive turn.
    always_comb
    begin
        s_signs_next = 2'b00;
        for (int t = 0; t < TURN_COUNT; t++)
        begin
            cross_val[t] = (PW+1)'(prod_ab_reg[t]) - (PW+1)'(prod_cd_reg[t]);
            if (p_ctrl_reg.turn_en[t])
            begin
                if (cross_val[t] < 0)
                begin
                    s_signs_next[0] = 1'b1;
                end
                else if (cross_val[t] != 0)
                begin
                    s_signs_next[1] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        merged = acc_reg | s_signs_reg;
        case (merged)
            2'b11:   class_next = CLASS_CONCAVE;
            2'b01:   class_next = CLASS_CONVEX;
            2'b10:   class_next = CLASS_CONVEX;
            default: class_next = CLASS_DEGENERATE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            acc_reg       <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg   <= job_valid;
            s_valid_reg   <= p_valid_reg;
            out_valid_reg <= s_valid_reg && s_last_reg;
            if (s_valid_reg)
            begin
                acc_reg <= s_last_reg ? 2'b00 : merged;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (job_valid)
            begin
                p_ctrl_reg <= job_ctrl;
                for (int t = 0; t < TURN_COUNT; t++)
                begin
                    prod_ab_reg[t] <=
                        PW'($signed(job_data[(t*TERM_COUNT+TERM_A)*DW +: DW])
                          * $signed(job_data[(t*TERM_COUNT+TERM_B)*DW +: DW]));
                    prod_cd_reg[t] <=
                        PW'($signed(job_data[(t*TERM_COUNT+TERM_C)*DW +: DW])
                          * $signed(job_data[(t*TERM_COUNT+TERM_D)*DW +: DW]));
                end
            end
            if (p_valid_reg)
            begin
                s_last_reg  <= p_ctrl_reg.last;
                s_signs_reg <= s_signs_next;
            end
            if (s_valid_reg && s_last_reg)
            begin
                class_reg <= class_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign shape_class = class_reg;

endmodule

/* rtl/polygon_convexity_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_convexity_classifier
// Classifies a polygon streamed one vertex per item as degenerate, convex or
// concave from the signs of the cross products of consecutive vertex triples.
// ----------------------------------------------------------------------------
// Usage:
// Vertices enter on the input channel (in_valid, in_stall) as signed x,y pairs
// with final_vertex set on the last vertex of each polygon. One class item
// leaves on the output channel (out_valid, out_stall) per polygon: 0 for fewer
// than three vertices or all turns zero, 1 for convex, 2 for concave.
// Throughput is one vertex per cycle while in_stall is low. With an empty job
// queue, the final vertex's job passes the queue, the multiplier stage and the
// sign stage before its class is shown in the output register.
// When out_stall holds a waiting class, the back pipeline freezes, the queue
// fills, and in_stall rises once the queue is full.
// Reset clears the vertex count, the queue, the pipeline valids and the turn
// flags, so the first vertex after reset starts a new polygon.
// ----------------------------------------------------------------------------
module polygon_convexity_classifier
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          final_vertex,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    shape_class
);

    localparam int DATA_W = TURN_COUNT * TERM_COUNT * (COORD_WIDTH + 1);
    localparam int JOB_W  = $bits(job_ctrl_t) + DATA_W;

    logic              accept;
    job_ctrl_t         push_ctrl;
    logic [DATA_W-1:0] push_data;
    logic              q_full;
    logic              q_valid;
    logic [JOB_W-1:0]  q_data;
    job_ctrl_t         pop_ctrl;
    logic [DATA_W-1:0] pop_data;
    logic              back_ready;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign pop_ctrl = q_data[JOB_W-1:DATA_W];
    assign pop_data = q_data[DATA_W-1:0];

    pcc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .final_vertex (final_vertex),
        .job_ctrl     (push_ctrl),
        .job_data     (push_data)
    );

    pcc_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (accept),
        .push_data  ({push_ctrl, push_data}),
        .full       (q_full),
        .pop_ready  (back_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    pcc_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job_ctrl    (pop_ctrl),
        .job_data    (pop_data),
        .job_ready   (back_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .shape_class (shape_class)
    );

endmodule
